@@ hw/rtl/fpa_pkg.sv @@
// Shared types and opcodes for the fixed-point ALU.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package fpa_pkg;

   localparam int WordWidth = 32;
   localparam int FracBitsDefault = 8;

   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_GT      = 4'd4;
   localparam logic [3:0] OP_LT      = 4'd5;
   localparam logic [3:0] OP_GE      = 4'd6;
   localparam logic [3:0] OP_LE      = 4'd7;
   localparam logic [3:0] OP_EQ      = 4'd8;
   localparam logic [3:0] OP_NE      = 4'd9;
   localparam logic [3:0] OP_MIN     = 4'd10;
   localparam logic [3:0] OP_MAX     = 4'd11;
   localparam logic [3:0] OP_INC     = 4'd12;
   localparam logic [3:0] OP_DEC     = 4'd13;
   localparam logic [3:0] OP_TOINT   = 4'd14;
   localparam logic [3:0] OP_FROMINT = 4'd15;

   typedef struct packed {
      logic [3:0]                  opcode;
      logic signed [WordWidth-1:0] operand_a;
      logic signed [WordWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] result;
      logic                        compare_true;
      logic                        div_by_zero;
      logic                        overflow;
   } rsp_type;

   // Everything that rides along the divider chain besides the divide state.
   typedef struct packed {
      logic [3:0]              opcode;
      logic                    neg;
      logic [WordWidth-1:0]    mb;
      logic [2*WordWidth-1:0]  prod;
      logic [WordWidth-1:0]    res;
      logic                    cmp;
      logic                    dz;
      logic                    ovf;
   } side_type;

endpackage

`default_nettype wire

@@ hw/rtl/fpa_prep.sv @@
// Entry stage: operand magnitudes, product, dividend and all simple ops.
// Depends on fpa_pkg.
`default_nettype none

module fpa_prep #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
   parameter int QW = fpa_pkg::WordWidth + FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire fpa_pkg::req_type                  in_data,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output fpa_pkg::side_type                      out_side,
   output logic [QW-1:0]                          out_nq
);
   localparam int W = fpa_pkg::WordWidth;

   logic            valid_ff;
   fpa_pkg::side_type side_ff, side_in;
   logic [QW-1:0]   nq_ff, nq_in;

   logic signed [W-1:0] a, b;
   logic [W-1:0]    ma, mb;
   logic [W:0]      sum, dif;
   logic [FRAC_BITS:0] top_bits;

   always_comb begin
      a = in_data.operand_a;
      b = in_data.operand_b;
      ma = a[W-1] ? W'(-a) : W'(a);
      mb = b[W-1] ? W'(-b) : W'(b);
      sum = {a[W-1], a} + {b[W-1], b};
      dif = {a[W-1], a} - {b[W-1], b};
      top_bits = a[W-1 -: FRAC_BITS+1];
      nq_in = QW'({ma, {FRAC_BITS{1'b0}}}) + QW'(mb >> 1);

      side_in.opcode = in_data.opcode;
      side_in.neg = a[W-1] ^ b[W-1];
      side_in.mb = mb;
      side_in.prod = ma * mb;
      side_in.res = '0;
      side_in.cmp = 1'b0;
      side_in.dz = 1'b0;
      side_in.ovf = 1'b0;
      unique case (in_data.opcode)
         fpa_pkg::OP_ADD: begin
            side_in.res = sum[W-1:0];
            side_in.ovf = sum[W] ^ sum[W-1];
         end
         fpa_pkg::OP_SUB: begin
            side_in.res = dif[W-1:0];
            side_in.ovf = dif[W] ^ dif[W-1];
         end
         fpa_pkg::OP_DIV: side_in.dz = (b == '0);
         fpa_pkg::OP_GT: side_in.cmp = a > b;
         fpa_pkg::OP_LT: side_in.cmp = a < b;
         fpa_pkg::OP_GE: side_in.cmp = a >= b;
         fpa_pkg::OP_LE: side_in.cmp = a <= b;
         fpa_pkg::OP_EQ: side_in.cmp = a == b;
         fpa_pkg::OP_NE: side_in.cmp = a != b;
         fpa_pkg::OP_MIN: side_in.res = (a < b) ? a : b;
         fpa_pkg::OP_MAX: side_in.res = (a > b) ? a : b;
         fpa_pkg::OP_INC: begin
            side_in.res = W'(a + 1);
            side_in.ovf = (a == {1'b0, {(W-1){1'b1}}});
         end
         fpa_pkg::OP_DEC: begin
            side_in.res = W'(a - 1);
            side_in.ovf = (a == {1'b1, {(W-1){1'b0}}});
         end
         fpa_pkg::OP_TOINT: side_in.res = a >>> FRAC_BITS;
         fpa_pkg::OP_FROMINT: begin
            side_in.res = a << FRAC_BITS;
            side_in.ovf = !((&top_bits) || !(|top_bits));
         end
         default: ;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         side_ff <= side_in;
         nq_ff <= nq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side = side_ff;
   assign out_nq = nq_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fpa_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on fpa_pkg.
`default_nettype none

module fpa_div_cell #(
   parameter int QW = fpa_pkg::WordWidth + fpa_pkg::FracBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire fpa_pkg::side_type            in_side,
   input  wire logic [fpa_pkg::WordWidth-1:0] in_rem,
   input  wire logic [QW-1:0]                in_nq,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output fpa_pkg::side_type                 out_side,
   output logic [fpa_pkg::WordWidth-1:0]     out_rem,
   output logic [QW-1:0]                     out_nq
);
   localparam int W = fpa_pkg::WordWidth;

   logic              valid_ff;
   fpa_pkg::side_type side_ff;
   logic [W-1:0]      rem_ff, rem_in;
   logic [QW-1:0]     nq_ff, nq_in;
   logic [W:0]        trial;
   logic              ge;

   // nq holds the unused dividend bits on top, quotient bits shift in below
   always_comb begin
      trial = {in_rem, in_nq[QW-1]};
      ge = trial >= {1'b0, in_side.mb};
      rem_in = ge ? W'(trial - {1'b0, in_side.mb}) : trial[W-1:0];
      nq_in = {in_nq[QW-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         rem_ff <= rem_in;
         nq_ff <= nq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side = side_ff;
   assign out_rem = rem_ff;
   assign out_nq = nq_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fpa_finish.sv @@
// Output stage: multiply rounding, divide sign, overflow, response register.
// Depends on fpa_pkg.
`default_nettype none

module fpa_finish #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
   parameter int QW = fpa_pkg::WordWidth + FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fpa_pkg::side_type in_side,
   input  wire logic [QW-1:0]     in_quo,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fpa_pkg::rsp_type       rsp_data
);
   localparam int W = fpa_pkg::WordWidth;
   localparam int PW = 2 * W;

   logic             valid_ff;
   fpa_pkg::rsp_type rsp_ff, rsp_in;
   logic [PW-1:0]    rounded, mag, sgn;

   always_comb begin
      rounded = (in_side.prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      mag = (in_side.opcode == fpa_pkg::OP_MUL) ? rounded : PW'(in_quo);
      sgn = in_side.neg ? PW'(-mag) : mag;
      rsp_in.result = in_side.res;
      rsp_in.compare_true = in_side.cmp;
      rsp_in.div_by_zero = in_side.dz;
      rsp_in.overflow = in_side.ovf;
      if (in_side.opcode == fpa_pkg::OP_MUL ||
          (in_side.opcode == fpa_pkg::OP_DIV && !in_side.dz)) begin
         rsp_in.result = sgn[W-1:0];
         rsp_in.overflow = in_side.neg ? (mag > (PW'(1) << (W - 1)))
                                       : (mag > ((PW'(1) << (W - 1)) - 1));
      end
   end

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fixed_point_alu.sv @@
// Top level of the fixed-point ALU: entry stage, divider cell chain, output stage.
// Depends on fpa_pkg, fpa_prep, fpa_div_cell, fpa_finish.
//
//   channel | ports                        | direction
//   req     | req_valid req_ready req_data | in
//   rsp     | rsp_valid rsp_ready rsp_data | out
//
// Every beat passes the entry stage, WordWidth + FRAC_BITS divider cells and
// the output register; one beat is accepted per cycle unless a low rsp_ready
// stalls the pipe. The divider chain sets the latency.
// Synchronous reset empties all stages. Stalls close bubbles stage by stage.
`default_nettype none

module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fpa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fpa_pkg::rsp_type      rsp_data
);
   localparam int W = fpa_pkg::WordWidth;
   localparam int QW = W + FRAC_BITS;

   logic              valid_c [QW+1];
   logic              ready_c [QW+1];
   fpa_pkg::side_type side_c  [QW+1];
   logic [W-1:0]      rem_c   [QW+1];
   logic [QW-1:0]     nq_c    [QW+1];

   assign rem_c[0] = '0;

   fpa_prep #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_prep (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(valid_c[0]), .out_ready(ready_c[0]),
      .out_side(side_c[0]), .out_nq(nq_c[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_cell
      fpa_div_cell #(.QW(QW)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(valid_c[i]), .in_ready(ready_c[i]),
         .in_side(side_c[i]), .in_rem(rem_c[i]), .in_nq(nq_c[i]),
         .out_valid(valid_c[i+1]), .out_ready(ready_c[i+1]),
         .out_side(side_c[i+1]), .out_rem(rem_c[i+1]), .out_nq(nq_c[i+1])
      );
   end

   fpa_finish #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_finish (
      .clock(clock), .reset(reset),
      .in_valid(valid_c[QW]), .in_ready(ready_c[QW]),
      .in_side(side_c[QW]), .in_quo(nq_c[QW]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // remainder of the last cell is not needed
   logic unused_rem;
   assign unused_rem = ^rem_c[QW];

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |->
         rsp_data.result == '0 && !rsp_data.overflow && !rsp_data.compare_true)
      else $error("divide by zero beat carries nonzero data");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_true |->
         rsp_data.result == '0 && !rsp_data.overflow)
      else $error("comparison beat carries result or overflow");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipe stalls with empty output");

endmodule

`default_nettype wire
